// ===== design/sumchk_pkg.sv =====
// Shared types and constants for the checksummed frame validator.
// Holds the frame phase and verdict codes, the result record and register map.
// No dependencies.
package sumchk_pkg;

  // Buffer size sets the cap on any declared payload length
  localparam int unsigned BUFFER_BYTES = 32768;
  localparam int unsigned LEN_W        = 15;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(BUFFER_BYTES - 8);

  // Reset value of the maximum payload length register
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(32760);

  // Frame marker bytes
  localparam logic [7:0] START0_BYTE = 8'hFB;
  localparam logic [7:0] START1_BYTE = 8'hFC;
  localparam logic [7:0] TERM_BYTE   = 8'h0D;

  // Index of the last of the little-endian length bytes after the start bytes
  localparam logic [LEN_W-1:0] LEN_BYTES_LAST = LEN_W'(3);

  // Configuration map: word index taken from paddr[2]
  localparam int unsigned ADDR_W       = 3;
  localparam logic        REG_MAX_LEN  = 1'b0;

  typedef enum logic [2:0] {
    PH_START0,
    PH_START1,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CHECK,
    PH_TERM,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    V_OK,
    V_BAD_START,
    V_BAD_LENGTH,
    V_BAD_SUM,
    V_BAD_TERM,
    V_SHORT
  } verdict_t;

  // One result per received byte
  typedef struct packed {
    logic [LEN_W-1:0] frame_length;
    verdict_t         verdict;
    logic             verdict_valid;
    logic             payload_valid;
    logic [7:0]       payload_byte;
  } result_t;

endpackage

// ===== design/sumchk_regs.sv =====
// Configuration register file for the frame validator.
// APB-style write and read of the maximum payload length register.
// Depends on sumchk_pkg.
module sumchk_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sumchk_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [sumchk_pkg::LEN_W-1:0]  max_len
);
  import sumchk_pkg::*;

  logic wr_en;
  logic [1:0] unused_addr;

  assign pready      = 1'b1;
  assign wr_en       = psel & penable & pwrite & pready;
  assign unused_addr = paddr[1:0];

  // Write the register on a completed access transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (wr_en && paddr[2] == REG_MAX_LEN) begin
      max_len <= pwdata[LEN_W-1:0];
    end
  end

  // Read back; byte lanes inside the word are not decoded
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_MAX_LEN && unused_addr == unused_addr) begin
      prdata = {{(32-LEN_W){1'b0}}, max_len};
    end
  end

endmodule

// ===== design/sumchk_core.sv =====
// Frame parsing state and per-byte result logic of the frame validator.
// One byte is consumed per accepted transaction; the result is combinational.
// Depends on sumchk_pkg.
module sumchk_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [7:0]                   rx_byte,
  input  logic                         buffer_end,
  input  logic [sumchk_pkg::LEN_W-1:0] max_len,
  output sumchk_pkg::result_t          res
);
  import sumchk_pkg::*;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [31:0]      length_shift, length_shift_next;
  logic [7:0]       running_sum, running_sum_next;

  logic [LEN_W-1:0] limit;
  logic [31:0]      len_word;
  logic             len_last;
  logic             len_bad;
  logic [LEN_W-1:0] count_inc;
  logic             pay_last;
  logic             decided;
  verdict_t         fail_code;

  // Effective length limit and length-field helpers
  assign limit     = (max_len < LEN_CAP) ? max_len : LEN_CAP;
  assign len_word  = {rx_byte, length_shift[31:8]};
  assign len_last  = (byte_count == LEN_BYTES_LAST);
  assign len_bad   = len_word[31] | (|len_word[30:LEN_W]) | (len_word[LEN_W-1:0] > limit);
  assign count_inc = byte_count + LEN_W'(1);
  assign pay_last  = (count_inc >= length_shift[LEN_W-1:0]);

  // Result for the current byte
  always_comb begin
    res       = '0;
    decided   = 1'b0;
    fail_code = V_OK;
    case (phase)
      PH_START0: begin
        if (rx_byte != START0_BYTE) begin
          decided   = 1'b1;
          fail_code = V_BAD_START;
        end
      end
      PH_START1: begin
        if (rx_byte != START1_BYTE) begin
          decided   = 1'b1;
          fail_code = V_BAD_START;
        end
      end
      PH_LENGTH: begin
        if (len_last && len_bad) begin
          decided   = 1'b1;
          fail_code = V_BAD_LENGTH;
        end
      end
      PH_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = rx_byte;
      end
      PH_CHECK: begin
        if (rx_byte != running_sum) begin
          decided   = 1'b1;
          fail_code = V_BAD_SUM;
        end
      end
      PH_TERM: begin
        decided = 1'b1;
        if (rx_byte == TERM_BYTE) begin
          res.frame_length = length_shift[LEN_W-1:0];
        end else begin
          fail_code = V_BAD_TERM;
        end
      end
      default: ;
    endcase
    if (decided) begin
      res.verdict_valid = 1'b1;
      res.verdict       = fail_code;
    end else if (buffer_end && phase != PH_DONE) begin
      res.verdict_valid = 1'b1;
      res.verdict       = V_SHORT;
    end
  end

  // Next parsing state
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    length_shift_next = length_shift;
    running_sum_next  = running_sum;
    case (phase)
      PH_START0: begin
        if (rx_byte == START0_BYTE) phase_next = PH_START1;
      end
      PH_START1: begin
        if (rx_byte == START1_BYTE) phase_next = PH_LENGTH;
      end
      PH_LENGTH: begin
        length_shift_next = len_word;
        byte_count_next   = count_inc;
        if (len_last) begin
          byte_count_next = '0;
          if (!len_bad) begin
            phase_next = (len_word == 32'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        running_sum_next = running_sum + rx_byte;
        byte_count_next  = count_inc;
        if (pay_last) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        if (rx_byte == running_sum) phase_next = PH_TERM;
      end
      default: ;
    endcase
    if (decided) phase_next = PH_DONE;
    // Rearm at the end of every buffer
    if (buffer_end) begin
      phase_next        = PH_START0;
      byte_count_next   = '0;
      length_shift_next = '0;
      running_sum_next  = '0;
    end
  end

  // Advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START0;
      byte_count   <= '0;
      length_shift <= '0;
      running_sum  <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      length_shift <= length_shift_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

// ===== design/sumchk_skid.sv =====
// Output register with a skid entry for the frame validator results.
// Keeps the input side ready while one result waits for the consumer.
// Depends on sumchk_pkg.
module sumchk_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sumchk_pkg::result_t in_res,
  output logic                out_valid,
  input  logic                out_ready,
  output sumchk_pkg::result_t out_res
);
  import sumchk_pkg::*;

  logic    skid_valid;
  result_t skid_res;
  logic    load_out;

  assign in_ready = ~skid_valid;
  assign load_out = ~out_valid | out_ready;

  // Control: output slot and skid slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= skid_valid | in_valid;
      skid_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: refill from skid first, else from the incoming transaction
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res <= skid_valid ? skid_res : in_res;
    end else if (in_valid && in_ready) begin
      skid_res <= in_res;
    end
  end

endmodule

// ===== design/sum_checked_frame_validator.sv =====
// Checksummed frame validator, top level: one received byte per transaction
// in, one result per byte out. Frame: FB FC, 4-byte little-endian length,
// payload, 8-bit additive checksum of the payload, 0D. Depends on sumchk_pkg,
// sumchk_regs, sumchk_core and sumchk_skid.
//
// Throughput is one byte per clock while s_tready is high: the parser state
// (phase, byte count, length shift register and running sum) is updated from
// the accepted byte, and the result is registered into the output stage. The
// output stage holds one extra result, so s_tready only drops once the
// consumer stalls with a result already waiting and a further result has
// been taken into the skid entry. Every buffer gets one
// verdict: ok, bad start, bad length, bad checksum, bad terminator or short
// buffer; bytes after the verdict give all-zero results until tlast, which
// rearms the parser. The length limit is the smaller of the max_payload_length
// register (address 0, reset 32760) and the buffer size less eight; write it
// only while no byte is in flight.
module sum_checked_frame_validator (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
  input  logic                          s_tlast,   // buffer_end
  // Result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // [7:0] payload_byte, [10:8] verdict,
                                                   // [25:11] frame_length, rest zero
  output logic [1:0]                    m_tuser,   // [0] payload_valid, [1] verdict_valid
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sumchk_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sumchk_pkg::*;

  logic [LEN_W-1:0] max_len;
  logic             accept;
  result_t          core_res;
  result_t          out_res;

  assign accept = s_tvalid & s_tready;

  sumchk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  sumchk_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (s_tdata),
    .buffer_end (s_tlast),
    .max_len    (max_len),
    .res        (core_res)
  );

  sumchk_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_res    (core_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Pack the result fields onto the stream
  assign m_tdata = {{(32-LEN_W-11){1'b0}}, out_res.frame_length, out_res.verdict,
                    out_res.payload_byte};
  assign m_tuser = {out_res.verdict_valid, out_res.payload_valid};

endmodule

// ===== design/sumchk_checker.sv =====
// Port-level checker for the checksummed frame validator.
// Watches the result stream only; bound to the top level below.
// Depends on sumchk_pkg.
module sumchk_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [31:0]                   m_tdata,
  input logic [1:0]                    m_tuser
);
  import sumchk_pkg::*;

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // Nothing offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

  // No verdict means zero verdict code and zero length
  a_no_verdict_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[25:8] == 18'd0)
    else $error("verdict fields set without verdict");

  // A frame length only comes with an ok verdict
  a_len_only_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25:11] != 15'd0 |-> m_tuser[1] && m_tdata[10:8] == V_OK)
    else $error("frame length without ok verdict");

  // Payload byte is zero outside the payload
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
    else $error("payload byte set outside payload");

endmodule

bind sum_checked_frame_validator sumchk_checker u_sumchk_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
